>>> rtl/zcfrm_pkg.sv
package zcfrm_pkg;

  localparam int SampleW    = 10;
  localparam int GainW      = 16;
  localparam int LevelFracW = 16;
  localparam int LevelW     = SampleW + LevelFracW;
  localparam int SquareW    = 40;
  localparam int CountW     = 16;
  localparam int FracW      = 8;
  localparam int PeriodW    = 24;
  localparam int BandW      = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 24;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 96;
  localparam int OutUserW   = 2;

  localparam logic [SampleW-1:0] OffsetRst      = SampleW'(512);
  localparam logic [GainW-1:0]   GainRst        = GainW'(19334);
  localparam logic [PeriodW-1:0] LowRestoreRst  = PeriodW'(77186);
  localparam logic [PeriodW-1:0] LowDisturbRst  = PeriodW'(76954);
  localparam logic [PeriodW-1:0] NormalRst      = PeriodW'(76647);
  localparam logic [PeriodW-1:0] HighDisturbRst = PeriodW'(76418);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET       = 3'd0,
    CFG_GAIN         = 3'd1,
    CFG_LOW_RESTORE  = 3'd2,
    CFG_LOW_DISTURB  = 3'd3,
    CFG_NORMAL       = 3'd4,
    CFG_HIGH_DISTURB = 3'd5
  } cfg_idx_e;

  typedef enum logic [BandW-1:0] {
    BAND_LOW_RESTORE  = 3'd0,
    BAND_LOW_DISTURB  = 3'd1,
    BAND_NORMAL       = 3'd2,
    BAND_HIGH_DISTURB = 3'd3,
    BAND_OVER         = 3'd4
  } band_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [SampleW-1:0] offset;
    logic [GainW-1:0]   gain;
    logic [LevelW-1:0]  level;
  } filt_req_t;

  typedef struct packed {
    logic                 done;
    logic [LevelW-1:0]    level;
    logic [2*SampleW-1:0] square;
  } filt_rsp_t;

  typedef struct packed {
    logic [LevelW-1:0] num;
    logic [LevelW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [FracW-1:0] frac;
  } div_rsp_t;

endpackage

>>> rtl/zcfrm_filter.sv
module zcfrm_filter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  zcfrm_pkg::filt_req_t  req_i,
  output zcfrm_pkg::filt_rsp_t  rsp_o
);
  import zcfrm_pkg::*;

  localparam int StepW = $clog2(GainW);

  logic                     busy_q, fin_q, done_q;
  logic [StepW-1:0]         step_q;
  logic [GainW-1:0]         gain_q;
  logic signed [LevelW:0]   diff_q, acc_q, acc_d;
  logic signed [LevelW+1:0] sum;
  logic signed [LevelW:0]   diff_start;
  logic [LevelW-1:0]        old_q, new_q;
  logic [2*SampleW-1:0]     mcand_q, sq_q;
  logic [SampleW-1:0]       mplier_q, mag;
  logic signed [LevelW:0]   new_full;

  // difference of the new sample (as Q.16) and the old level
  assign diff_start = {1'b0, req_i.sample, {LevelFracW{1'b0}}} - {1'b0, req_i.level};
  assign mag = (req_i.sample >= req_i.offset) ? (req_i.sample - req_i.offset)
                                              : (req_i.offset - req_i.sample);

  // LSB-first gain bit: add the difference, then halve with floor
  always_comb begin
    sum   = {acc_q[LevelW], acc_q} + (gain_q[0] ? {diff_q[LevelW], diff_q} : '0);
    acc_d = sum[LevelW+1:1];
  end

  assign new_full = $signed({1'b0, old_q}) + acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(GainW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gain_q   <= req_i.gain;
      diff_q   <= diff_start;
      acc_q    <= '0;
      old_q    <= req_i.level;
      mcand_q  <= {{SampleW{1'b0}}, mag};
      mplier_q <= mag;
      sq_q     <= '0;
    end else if (busy_q) begin
      gain_q   <= gain_q >> 1;
      acc_q    <= acc_d;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      if (mplier_q[0]) begin
        sq_q <= sq_q + mcand_q;
      end
    end else if (fin_q) begin
      new_q <= new_full[LevelW-1:0];
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.level  = new_q;
  assign rsp_o.square = sq_q;

endmodule

>>> rtl/zcfrm_frac_div.sv
module zcfrm_frac_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  zcfrm_pkg::div_req_t  req_i,
  output zcfrm_pkg::div_rsp_t  rsp_o
);
  import zcfrm_pkg::*;

  localparam int StepW = $clog2(FracW);

  logic              busy_q, done_q;
  logic [StepW-1:0]  step_q;
  logic [LevelW-1:0] rem_q, den_q;
  logic [FracW-1:0]  quo_q;
  logic [LevelW:0]   rem2, diff;
  logic              take;

  // remainder stays below the divisor, so doubling fits one extra bit
  always_comb begin
    rem2 = {rem_q, 1'b0};
    diff = rem2 - {1'b0, den_q};
    take = (rem2 >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(FracW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= req_i.num;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff[LevelW-1:0] : rem2[LevelW-1:0];
      quo_q <= {quo_q[FracW-2:0], take};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.frac = quo_q;

endmodule

>>> rtl/zero_cross_frequency_rms_meter_unit.sv
// Channel   Dir  Handshake                      Contents
// s_axis    in   s_axis_tvalid / s_axis_tready  one raw ADC sample
// m_axis    out  m_axis_tvalid / m_axis_tready  filter level, crossing report
// cfg       in   cfg_we_i                       register index and write data
//
// One sample at a time: the input takes no new sample until the result of the last
// one has entered the output register.
// The 16-step serial filter multiply (square runs alongside) runs for every sample;
// a crossing adds the 8-step fraction divide.
// The output register holds a result while the next sample is taken in; a result
// still waiting then holds the next one back in ST_EMIT until the output is free.
// rst_ni clears the control state and outputs and loads the register defaults; no clearing pass.
module zero_cross_frequency_rms_meter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [zcfrm_pkg::InDataW-1:0]      s_axis_tdata,  // sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // filtered_sample, period_q8, square_sum, sample_count, band, zero pad
  output logic [zcfrm_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic [zcfrm_pkg::OutUserW-1:0]     m_axis_tuser,  // crossing, period_valid
  input  logic                               cfg_we_i,
  input  logic [zcfrm_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [zcfrm_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import zcfrm_pkg::*;

  localparam int PerExtW = CountW + FracW + 1;
  localparam int PadW    = OutDataW - (SampleW + PeriodW + SquareW + CountW + BandW);

  typedef enum logic [2:0] {ST_IDLE, ST_FILT, ST_DIV, ST_EMIT} state_e;

  state_e state_q;

  logic [SampleW-1:0] offset_q;
  logic [GainW-1:0]   gain_q;
  logic [PeriodW-1:0] low_restore_q, low_disturb_q, normal_q, high_disturb_q;

  logic [LevelW-1:0]  level_q;
  logic [SquareW-1:0] sqacc_q;
  logic [CountW-1:0]  count_q;
  logic [FracW-1:0]   prev_frac_q, frac_q;
  logic               seen_q, cross_q;
  logic [PeriodW-1:0] period_q;

  filt_req_t filt_req;
  filt_rsp_t filt_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      filt_start, div_start;

  logic [LevelW-1:0]  off_lvl;
  logic               cross_now;
  logic [SquareW:0]   sq_sum;
  logic [PerExtW-1:0] per_ext;
  logic [BandW-1:0]   band;
  logic               out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign filt_start    = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign filt_req.sample = s_axis_tdata[SampleW-1:0];
  assign filt_req.offset = offset_q;
  assign filt_req.gain   = gain_q;
  assign filt_req.level  = level_q;

  assign off_lvl   = {offset_q, {LevelFracW{1'b0}}};
  assign cross_now = (filt_rsp.level > off_lvl) && (level_q < off_lvl);
  assign div_start = (state_q == ST_FILT) && filt_rsp.done && cross_now;
  assign div_req.num = filt_rsp.level - off_lvl;
  assign div_req.den = filt_rsp.level - level_q;

  assign sq_sum  = {1'b0, sqacc_q} + {{(SquareW+1-2*SampleW){1'b0}}, filt_rsp.square};
  assign per_ext = {1'b0, count_q, {FracW{1'b0}}}
                 - {{(PerExtW-FracW){1'b0}}, div_rsp.frac}
                 + {{(PerExtW-FracW){1'b0}}, prev_frac_q};

  always_comb begin
    priority if (period_q > low_restore_q) band = BAND_LOW_RESTORE;
    else if (period_q > low_disturb_q)     band = BAND_LOW_DISTURB;
    else if (period_q > normal_q)          band = BAND_NORMAL;
    else if (period_q > high_disturb_q)    band = BAND_HIGH_DISTURB;
    else                                   band = BAND_OVER;
  end

  zcfrm_filter u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (filt_start),
    .req_i   (filt_req),
    .rsp_o   (filt_rsp)
  );

  zcfrm_frac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .rsp_o   (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q       <= OffsetRst;
      gain_q         <= GainRst;
      low_restore_q  <= LowRestoreRst;
      low_disturb_q  <= LowDisturbRst;
      normal_q       <= NormalRst;
      high_disturb_q <= HighDisturbRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_OFFSET:       offset_q       <= cfg_wdata_i[SampleW-1:0];
        CFG_GAIN:         gain_q         <= cfg_wdata_i[GainW-1:0];
        CFG_LOW_RESTORE:  low_restore_q  <= cfg_wdata_i[PeriodW-1:0];
        CFG_LOW_DISTURB:  low_disturb_q  <= cfg_wdata_i[PeriodW-1:0];
        CFG_NORMAL:       normal_q       <= cfg_wdata_i[PeriodW-1:0];
        CFG_HIGH_DISTURB: high_disturb_q <= cfg_wdata_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      level_q       <= '0;
      sqacc_q       <= '0;
      count_q       <= '0;
      prev_frac_q   <= '0;
      frac_q        <= '0;
      period_q      <= '0;
      seen_q        <= 1'b0;
      cross_q       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= '0;
    end else begin
      // drop valid after the transfer unless the next result goes out now
      if (m_axis_tvalid && m_axis_tready && state_q != ST_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (filt_start) begin
            state_q <= ST_FILT;
          end
        end
        ST_FILT: begin
          if (filt_rsp.done) begin
            level_q <= filt_rsp.level;
            cross_q <= cross_now;
            sqacc_q <= sq_sum[SquareW] ? {SquareW{1'b1}} : sq_sum[SquareW-1:0];
            if (count_q != {CountW{1'b1}}) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= cross_now ? ST_DIV : ST_EMIT;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            frac_q   <= div_rsp.frac;
            // hold at the top code if the interval overflows
            period_q <= (per_ext > PerExtW'({PeriodW{1'b1}})) ? {PeriodW{1'b1}}
                                                               : per_ext[PeriodW-1:0];
            state_q  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= {cross_q && seen_q, cross_q};
            if (cross_q) begin
              m_axis_tdata <= {{PadW{1'b0}},
                               seen_q ? band : BAND_LOW_RESTORE,
                               count_q,
                               sqacc_q,
                               seen_q ? period_q : {PeriodW{1'b0}},
                               level_q[LevelW-1:LevelFracW]};
            end else begin
              m_axis_tdata <= {{(OutDataW-SampleW){1'b0}}, level_q[LevelW-1:LevelFracW]};
            end
            state_q       <= ST_IDLE;
            if (cross_q) begin
              sqacc_q     <= '0;
              count_q     <= '0;
              prev_frac_q <= frac_q;
              seen_q      <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/zcfrm_checker.sv
module zcfrm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [zcfrm_pkg::InDataW-1:0]      s_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [zcfrm_pkg::OutDataW-1:0]     m_axis_tdata,
  input logic [zcfrm_pkg::OutUserW-1:0]     m_axis_tuser,
  input logic                               cfg_we_i,
  input logic [zcfrm_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input logic [zcfrm_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import zcfrm_pkg::*;

  localparam int ReportLo = SampleW;
  localparam int ReportHi = SampleW + PeriodW + SquareW + CountW + BandW - 1;
  localparam int CountLo  = SampleW + PeriodW + SquareW;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one sample in flight: the input closes after each transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while busy");

  a_valid_needs_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("period valid without crossing");

  a_quiet_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[ReportHi:ReportLo] == '0)
    else $error("report fields set without crossing");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[CountLo+CountW-1:CountLo] != '0)
    else $error("crossing reported with zero sample count");

endmodule

bind zero_cross_frequency_rms_meter_unit zcfrm_checker u_zcfrm_checker (.*);
